// ----- design/phfe_pkg.sv -----
// shared types and constants of the packet header field extractor
`default_nettype none

package phfe_pkg;

    localparam logic [16:0] MAX_FRAME_BYTES = 17'd65535;

    localparam logic [15:0] ETYPE_VLAN_Q  = 16'h8100;
    localparam logic [15:0] ETYPE_VLAN_AD = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;

    localparam logic [4:0] L3_UNTAGGED = 5'd14;
    localparam logic [4:0] L3_TAGGED   = 5'd18;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] ICMP_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] ICMP6_PING_REQUEST = 8'd128;
    localparam logic [7:0] ICMP6_PING_ANSWER  = 8'd129;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_IPV4 = 2'd1;
    localparam logic [1:0] KIND_IPV6 = 2'd2;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [1:0]  ip_kind;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
        logic [7:0]  protocol_number;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        tcp_syn_seen;
        logic [15:0] packet_length;
    } result_t;

endpackage

`default_nettype wire

// ----- design/phfe_if.sv -----
// channel interfaces: frame bytes in, header words out
`default_nettype none

interface phfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface phfe_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  ip_kind;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [7:0]  protocol_number;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        tcp_syn_seen;
    logic [15:0] packet_length;

    modport source (output valid, output ip_kind, output source_addr_high,
                    output source_addr_low, output dest_addr_high, output dest_addr_low,
                    output protocol_number, output source_port, output dest_port,
                    output tcp_syn_seen, output packet_length, input ready);
    modport sink (input valid, input ip_kind, input source_addr_high,
                  input source_addr_low, input dest_addr_high, input dest_addr_low,
                  input protocol_number, input source_port, input dest_port,
                  input tcp_syn_seen, input packet_length, output ready);
endinterface

`default_nettype wire

// ----- design/phfe_in_stage.sv -----
// input register for frame bytes
`default_nettype none

module phfe_in_stage
    import phfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    phfe_byte_if.sink       frame,
    input  wire logic       take,
    output byte_word_t      word,
    output logic            word_valid
);

    logic       valid_reg;
    logic       valid_next;
    byte_word_t word_reg;

    assign frame.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (frame.valid && frame.ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            word_reg.packet_byte <= frame.packet_byte;
            word_reg.last_byte   <= frame.last_byte;
        end
    end

    assign word       = word_reg;
    assign word_valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/phfe_parse.sv -----
// per-frame parse state and result assembly
`default_nettype none

module phfe_parse
    import phfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire byte_word_t word,
    input  wire logic       step,
    output result_t         result
);

    logic [15:0] byte_offset_reg;
    logic [15:0] ethertype_reg;
    logic [4:0]  l3_reg;
    logic [7:0]  l4_reg;
    logic [63:0] hs_reg [4];
    logic [47:0] l4f_reg;
    logic [7:0]  proto_reg;
    logic        syn_reg;

    logic [15:0] ethertype_next;
    logic [4:0]  l3_next;
    logic [7:0]  l4_next;
    logic [63:0] hs_next [4];
    logic [47:0] l4f_next;
    logic [7:0]  proto_next;
    logic        syn_next;

    logic [7:0]  b;
    logic [15:0] p;
    logic [15:0] eth_shift;
    logic [15:0] rel;
    logic [5:0]  rel6;
    logic [5:0]  rel_v6;
    logic        in_l3;
    logic [15:0] l4w;
    logic [15:0] r;
    logic [16:0] len;
    logic        v4;
    logic        v6;
    logic [7:0]  icmp_type;

    assign b = word.packet_byte;
    assign p = byte_offset_reg;

    always_comb
    begin
        eth_shift      = {ethertype_reg[7:0], b};
        ethertype_next = ethertype_reg;
        l3_next        = l3_reg;
        if (p == 16'd12 || p == 16'd13)
        begin
            ethertype_next = eth_shift;
            if (p == 16'd13 && (eth_shift == ETYPE_VLAN_Q || eth_shift == ETYPE_VLAN_AD))
            begin
                l3_next = L3_TAGGED;
            end
        end
        else if (l3_reg == L3_TAGGED && (p == 16'd16 || p == 16'd17))
        begin
            ethertype_next = eth_shift;
        end

        // ip header capture
        rel        = p - {11'd0, l3_next};
        in_l3      = (p >= {11'd0, l3_next}) && (rel < 16'd40);
        rel6       = rel[5:0];
        rel_v6     = rel6 - 6'd8;
        l4_next    = l4_reg;
        proto_next = proto_reg;
        hs_next    = hs_reg;
        if (in_l3)
        begin
            if (ethertype_next == ETYPE_IPV4)
            begin
                if (rel6 == 6'd0)
                begin
                    l4_next = {3'd0, l3_next} + {2'd0, b[3:0], 2'b00};
                end
                else if (rel6 == 6'd9)
                begin
                    proto_next = b;
                end
                else if (rel6 >= 6'd12 && rel6 < 6'd16)
                begin
                    hs_next[1] = {hs_reg[1][55:0], b};
                end
                else if (rel6 >= 6'd16 && rel6 < 6'd20)
                begin
                    hs_next[3] = {hs_reg[3][55:0], b};
                end
            end
            else if (ethertype_next == ETYPE_IPV6)
            begin
                if (rel6 == 6'd0)
                begin
                    l4_next = {3'd0, l3_next} + 8'd40;
                end
                else if (rel6 == 6'd6)
                begin
                    proto_next = b;
                end
                else if (rel6 >= 6'd8)
                begin
                    hs_next[rel_v6[4:3]] = {hs_reg[rel_v6[4:3]][55:0], b};
                end
            end
        end

        // l4 header capture
        l4w      = {8'd0, l4_next};
        r        = p - l4w;
        l4f_next = l4f_reg;
        syn_next = syn_reg;
        if (l4_next != 8'd0 && p >= l4w)
        begin
            if (r < 16'd6)
            begin
                l4f_next = {l4f_reg[39:0], b};
            end
            else if (r == 16'd13)
            begin
                syn_next = b[1];
            end
        end

        // result
        len       = {1'b0, p} + 17'd1;
        v4        = (ethertype_next == ETYPE_IPV4) && (len >= {12'd0, l3_next} + 17'd20);
        v6        = (ethertype_next == ETYPE_IPV6) && (len >= {12'd0, l3_next} + 17'd40);
        icmp_type = l4f_next[47:40];
        result    = '0;
        result.packet_length = (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES[15:0] : len[15:0];
        if (v4 || v6)
        begin
            result.ip_kind         = v4 ? KIND_IPV4 : KIND_IPV6;
            result.protocol_number = proto_next;
            if (v4)
            begin
                result.source_addr_low = {32'd0, hs_next[1][31:0]};
                result.dest_addr_low   = {32'd0, hs_next[3][31:0]};
            end
            else
            begin
                result.source_addr_high = hs_next[0];
                result.source_addr_low  = hs_next[1];
                result.dest_addr_high   = hs_next[2];
                result.dest_addr_low    = hs_next[3];
            end
            if (proto_next == PROTO_TCP && len >= {9'd0, l4_next} + 17'd20)
            begin
                result.source_port  = l4f_next[47:32];
                result.dest_port    = l4f_next[31:16];
                result.tcp_syn_seen = syn_next;
            end
            else if (proto_next == PROTO_UDP && len >= {9'd0, l4_next} + 17'd8)
            begin
                result.source_port = l4f_next[47:32];
                result.dest_port   = l4f_next[31:16];
            end
            else if (v4 && proto_next == PROTO_ICMP && len >= {9'd0, l4_next} + 17'd8)
            begin
                if (icmp_type == ICMP_ECHO_REQUEST || icmp_type == ICMP_ECHO_REPLY)
                begin
                    result.source_port = l4f_next[15:0];
                end
            end
            else if (v6 && proto_next == PROTO_ICMPV6 && len >= {9'd0, l4_next} + 17'd8)
            begin
                if (icmp_type == ICMP6_PING_REQUEST || icmp_type == ICMP6_PING_ANSWER)
                begin
                    result.source_port = l4f_next[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
            ethertype_reg   <= '0;
            l3_reg          <= L3_UNTAGGED;
            l4_reg          <= '0;
            hs_reg          <= '{default: '0};
            l4f_reg         <= '0;
            proto_reg       <= '0;
            syn_reg         <= 1'b0;
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                byte_offset_reg <= '0;
                ethertype_reg   <= '0;
                l3_reg          <= L3_UNTAGGED;
                l4_reg          <= '0;
                hs_reg          <= '{default: '0};
                l4f_reg         <= '0;
                proto_reg       <= '0;
                syn_reg         <= 1'b0;
            end
            else
            begin
                if (byte_offset_reg != 16'hFFFF)
                begin
                    byte_offset_reg <= byte_offset_reg + 16'd1;
                end
                ethertype_reg <= ethertype_next;
                l3_reg        <= l3_next;
                l4_reg        <= l4_next;
                hs_reg        <= hs_next;
                l4f_reg       <= l4f_next;
                proto_reg     <= proto_next;
                syn_reg       <= syn_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/packet_header_field_extractor.sv -----
// top level: ethernet / ip / l4 header field extractor
// frame: one byte word per handshake from the destination mac on, last_byte
//   marks the final byte of the frame
// header: one word per frame with ip kind, addresses, protocol, l4 ports,
//   tcp syn flag and frame length
// a byte is registered on acceptance and parsed from the input register; the word
//   for a frame is registered in the header register when its last byte is taken
// one byte per cycle sustained unless a last byte waits; the parse state update
//   and result assembly sit between the input register and the header register
// when header is stalled, bytes of the next frame keep flowing until its last
//   byte reaches the parse stage, which then waits for the header register
// reset clears the parse state, the input register valid and the header valid
// frames over 65535 bytes report a length of 65535
`default_nettype none

module packet_header_field_extractor
    import phfe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    phfe_byte_if.sink     frame,
    phfe_result_if.source header
);

    byte_word_t word;
    logic       word_valid;
    logic       take;
    logic       step;
    result_t    result;
    result_t    result_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign take = word_valid && (!word.last_byte || !out_valid_reg || header.ready);
    assign step = take;

    phfe_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .take       (take),
        .word       (word),
        .word_valid (word_valid)
    );

    phfe_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .word   (word),
        .step   (step),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && word.last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (header.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && word.last_byte)
        begin
            result_reg <= result;
        end
    end

    assign header.valid            = out_valid_reg;
    assign header.ip_kind          = result_reg.ip_kind;
    assign header.source_addr_high = result_reg.source_addr_high;
    assign header.source_addr_low  = result_reg.source_addr_low;
    assign header.dest_addr_high   = result_reg.dest_addr_high;
    assign header.dest_addr_low    = result_reg.dest_addr_low;
    assign header.protocol_number  = result_reg.protocol_number;
    assign header.source_port      = result_reg.source_port;
    assign header.dest_port        = result_reg.dest_port;
    assign header.tcp_syn_seen     = result_reg.tcp_syn_seen;
    assign header.packet_length    = result_reg.packet_length;

endmodule

`default_nettype wire

// ----- test/packet_header_field_extractor_tb.sv -----
// testbench for the packet header field extractor: random and directed frames checked per header word
module packet_header_field_extractor_tb;
    import phfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int FORCED_HOLD = 400;

    logic clk;
    logic rst_n;

    phfe_byte_if   frame_bus ();
    phfe_result_if header_bus ();

    packet_header_field_extractor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_bus),
        .header (header_bus)
    );

    byte_word_t queued_bytes [$];
    result_t    predicted_headers [$];

    logic [15:0] byte_pos;
    logic [15:0] ether_type;
    logic [4:0]  l3_at;
    logic [7:0]  l4_at;
    logic [63:0] addr_words [4];
    logic [47:0] l4_head;
    logic [7:0]  ip_proto;
    logic        syn_flag;

    bit byte_took = 1'b0;
    bit word_took = 1'b0;
    bit offering = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    bit held_once = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int headers_seen = 0;
    int error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_parse();
        byte_pos = '0;
        ether_type = '0;
        l3_at = L3_UNTAGGED;
        l4_at = '0;
        for (int i = 0; i < 4; i++)
        begin
            addr_words[i] = '0;
        end
        l4_head = '0;
        ip_proto = '0;
        syn_flag = 1'b0;
    endfunction

    function automatic bit parse_frame_byte(input byte_word_t w, output result_t res);
        logic [7:0]  b;
        logic [16:0] len;
        logic [7:0]  icmp_type;
        int          rel;
        int          l4_rel;
        int          slot;
        bit          v4;
        bit          v6;
        b = w.packet_byte;
        res = '0;
        if (byte_pos == 16'd12 || byte_pos == 16'd13)
        begin
            ether_type = {ether_type[7:0], b};
            if (byte_pos == 16'd13 && (ether_type == ETYPE_VLAN_Q || ether_type == ETYPE_VLAN_AD))
            begin
                l3_at = L3_TAGGED;
            end
        end
        else if (l3_at == L3_TAGGED && (byte_pos == 16'd16 || byte_pos == 16'd17))
        begin
            ether_type = {ether_type[7:0], b};
        end

        rel = int'(byte_pos) - int'(l3_at);
        if (rel >= 0 && rel < 40)
        begin
            if (ether_type == ETYPE_IPV4)
            begin
                if (rel == 0)
                begin
                    l4_at = 8'(l3_at + 4 * b[3:0]);
                end
                else if (rel == 9)
                begin
                    ip_proto = b;
                end
                else if (rel >= 12 && rel < 16)
                begin
                    addr_words[1] = {addr_words[1][55:0], b};
                end
                else if (rel >= 16 && rel < 20)
                begin
                    addr_words[3] = {addr_words[3][55:0], b};
                end
            end
            else if (ether_type == ETYPE_IPV6)
            begin
                if (rel == 0)
                begin
                    l4_at = 8'(l3_at + 40);
                end
                else if (rel == 6)
                begin
                    ip_proto = b;
                end
                else if (rel >= 8)
                begin
                    slot = (rel - 8) >> 3;
                    addr_words[slot] = {addr_words[slot][55:0], b};
                end
            end
        end

        if (l4_at != 0 && int'(byte_pos) >= int'(l4_at))
        begin
            l4_rel = int'(byte_pos) - int'(l4_at);
            if (l4_rel < 6)
            begin
                l4_head = {l4_head[39:0], b};
            end
            else if (l4_rel == 13)
            begin
                syn_flag = b[1];
            end
        end

        if (!w.last_byte)
        begin
            if (byte_pos != 16'hFFFF)
            begin
                byte_pos = byte_pos + 16'd1;
            end
            return 1'b0;
        end

        len = {1'b0, byte_pos} + 17'd1;
        v4 = ether_type == ETYPE_IPV4 && int'(len) >= int'(l3_at) + 20;
        v6 = ether_type == ETYPE_IPV6 && int'(len) >= int'(l3_at) + 40;
        icmp_type = l4_head[47:40];
        if (v4 || v6)
        begin
            res.ip_kind = v4 ? KIND_IPV4 : KIND_IPV6;
            res.protocol_number = ip_proto;
            if (v4)
            begin
                res.source_addr_low = {32'd0, addr_words[1][31:0]};
                res.dest_addr_low = {32'd0, addr_words[3][31:0]};
            end
            else
            begin
                res.source_addr_high = addr_words[0];
                res.source_addr_low = addr_words[1];
                res.dest_addr_high = addr_words[2];
                res.dest_addr_low = addr_words[3];
            end
            if (ip_proto == PROTO_TCP && int'(len) >= int'(l4_at) + 20)
            begin
                res.source_port = l4_head[47:32];
                res.dest_port = l4_head[31:16];
                res.tcp_syn_seen = syn_flag;
            end
            else if (ip_proto == PROTO_UDP && int'(len) >= int'(l4_at) + 8)
            begin
                res.source_port = l4_head[47:32];
                res.dest_port = l4_head[31:16];
            end
            else if (v4 && ip_proto == PROTO_ICMP && int'(len) >= int'(l4_at) + 8)
            begin
                if (icmp_type == ICMP_ECHO_REQUEST || icmp_type == ICMP_ECHO_REPLY)
                begin
                    res.source_port = l4_head[15:0];
                end
            end
            else if (v6 && ip_proto == PROTO_ICMPV6 && int'(len) >= int'(l4_at) + 8)
            begin
                if (icmp_type == ICMP6_PING_REQUEST || icmp_type == ICMP6_PING_ANSWER)
                begin
                    res.source_port = l4_head[15:0];
                end
            end
        end
        res.packet_length = (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES[15:0] : len[15:0];
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic push_bytes(input logic [7:0] f [$]);
        for (int i = 0; i < f.size(); i++)
        begin
            queued_bytes.push_back('{packet_byte: f[i], last_byte: (i == f.size() - 1)});
        end
    endtask

    task automatic push_frame(input int tags, input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [7:0] l4_type,
                              input logic [7:0] tcp_flags, input int payload, input int cut);
        logic [7:0]  f [$];
        logic [15:0] tag;
        int          hdr_len;
        repeat (12) f.push_back(8'($urandom));
        repeat (tags)
        begin
            tag = $urandom_range(0, 1) ? ETYPE_VLAN_Q : ETYPE_VLAN_AD;
            f.push_back(tag[15:8]);
            f.push_back(tag[7:0]);
            f.push_back(8'($urandom));
            f.push_back(8'($urandom));
        end
        f.push_back(etype[15:8]);
        f.push_back(etype[7:0]);
        if (etype == ETYPE_IPV4)
        begin
            hdr_len = (ihl > 4'd5) ? 4 * ihl : 20;
            for (int i = 0; i < hdr_len; i++)
            begin
                if (i == 0)
                    f.push_back({4'h4, ihl});
                else if (i == 9)
                    f.push_back(proto);
                else
                    f.push_back(8'($urandom));
            end
        end
        else if (etype == ETYPE_IPV6)
        begin
            for (int i = 0; i < 40; i++)
            begin
                if (i == 0)
                    f.push_back({4'h6, 4'($urandom)});
                else if (i == 6)
                    f.push_back(proto);
                else
                    f.push_back(8'($urandom));
            end
        end
        for (int i = 0; i < 20; i++)
        begin
            if (i == 0)
                f.push_back(l4_type);
            else if (i == 13)
                f.push_back(tcp_flags);
            else
                f.push_back(8'($urandom));
        end
        repeat (payload) f.push_back(8'($urandom));
        while (cut > 0 && f.size() > cut)
        begin
            void'(f.pop_back());
        end
        push_bytes(f);
    endtask

    // score accepted bytes and header words
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            byte_took = frame_bus.valid && frame_bus.ready;
            word_took = header_bus.valid && header_bus.ready;
            if (word_took)
            begin
                headers_seen++;
                got = {header_bus.ip_kind, header_bus.source_addr_high,
                       header_bus.source_addr_low, header_bus.dest_addr_high,
                       header_bus.dest_addr_low, header_bus.protocol_number,
                       header_bus.source_port, header_bus.dest_port,
                       header_bus.tcp_syn_seen, header_bus.packet_length};
                if (predicted_headers.size() == 0)
                begin
                    $error("header word with no frame pending, length %0d", got.packet_length);
                    error_count++;
                end
                else
                begin
                    want = predicted_headers.pop_front();
                    check_field("ip_kind", 64'(want.ip_kind), 64'(got.ip_kind));
                    check_field("source_addr_high", want.source_addr_high, got.source_addr_high);
                    check_field("source_addr_low", want.source_addr_low, got.source_addr_low);
                    check_field("dest_addr_high", want.dest_addr_high, got.dest_addr_high);
                    check_field("dest_addr_low", want.dest_addr_low, got.dest_addr_low);
                    check_field("protocol_number", 64'(want.protocol_number),
                                64'(got.protocol_number));
                    check_field("source_port", 64'(want.source_port), 64'(got.source_port));
                    check_field("dest_port", 64'(want.dest_port), 64'(got.dest_port));
                    check_field("tcp_syn_seen", 64'(want.tcp_syn_seen), 64'(got.tcp_syn_seen));
                    check_field("packet_length", 64'(want.packet_length),
                                64'(got.packet_length));
                end
            end
            if (byte_took)
            begin
                if (parse_frame_byte({frame_bus.packet_byte, frame_bus.last_byte}, want))
                begin
                    predicted_headers.push_back(want);
                end
            end
            if (byte_took || word_took)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_took)
            begin
                void'(queued_bytes.pop_front());
                offering = 1'b0;
                send_gap = pick_gap(send_calm);
            end
            if ($urandom_range(0, 199) == 0)
            begin
                send_calm = !send_calm;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (queued_bytes.size() != 0)
                    offering = 1'b1;
            end
            frame_bus.valid <= offering;
            if (offering)
            begin
                frame_bus.packet_byte <= queued_bytes[0].packet_byte;
                frame_bus.last_byte <= queued_bytes[0].last_byte;
            end
        end
    end

    // header ready, with random gaps and holds and one long hold-off once four words have passed
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!held_once && headers_seen >= 4)
            begin
                hold_left = FORCED_HOLD;
                held_once = 1'b1;
            end
            else if (hold_left == 0 && $urandom_range(0, 599) == 0)
            begin
                hold_left = $urandom_range(60, 200);
            end
            if ($urandom_range(0, 199) == 0)
            begin
                recv_calm = !recv_calm;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                header_bus.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                header_bus.ready <= 1'b0;
            end
            else
            begin
                header_bus.ready <= 1'b1;
                recv_gap = pick_gap(recv_calm);
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [7:0]  raw [$];
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [7:0]  l4_type;
        int          roll;
        int          cut;
        int          payload;
        int          tags;

        rst_n = 1'b0;
        frame_bus.valid = 1'b0;
        frame_bus.packet_byte = '0;
        frame_bus.last_byte = 1'b0;
        header_bus.ready = 1'b0;
        clear_parse();

        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 8'h02, 4, 0);
        push_frame(1, ETYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 8'hFD, 0, 0);
        push_frame(1, ETYPE_IPV4, 4'd5, PROTO_UDP, 8'h12, 8'h00, 3, 0);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REQUEST, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_ICMP, ICMP_ECHO_REPLY, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_ICMP, 8'd3, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV6, 4'd0, PROTO_TCP, 8'h00, 8'hFF, 2, 0);
        push_frame(1, ETYPE_IPV6, 4'd0, PROTO_UDP, 8'h00, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV6, 4'd0, PROTO_ICMPV6, ICMP6_PING_REQUEST, 8'h00, 0, 0);
        push_frame(1, ETYPE_IPV6, 4'd0, PROTO_ICMPV6, ICMP6_PING_ANSWER, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV6, 4'd0, PROTO_ICMPV6, 8'd1, 8'h00, 0, 0);
        // echo codes under the other ip version give no identifier
        push_frame(0, ETYPE_IPV6, 4'd0, PROTO_ICMP, ICMP_ECHO_REQUEST, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_ICMPV6, ICMP6_PING_REQUEST, 8'h00, 0, 0);
        push_frame(0, ETYPE_IPV4, 4'd5, 8'd47, 8'h00, 8'h00, 0, 0);
        push_frame(0, 16'h88CC, 4'd5, PROTO_UDP, 8'h00, 8'h00, 10, 0);
        push_frame(2, ETYPE_IPV4, 4'd5, PROTO_UDP, 8'h00, 8'h00, 0, 0);
        // cut inside the ip header, then inside the l4 header
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 8'h02, 0, 33);
        push_frame(0, ETYPE_IPV6, 4'd0, PROTO_TCP, 8'h00, 8'h02, 0, 53);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 8'h02, 0, 53);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_UDP, 8'h00, 8'h00, 0, 41);
        push_frame(0, ETYPE_IPV4, 4'd0, PROTO_TCP, 8'h00, 8'h02, 0, 0);
        push_frame(1, ETYPE_IPV4, 4'd15, PROTO_TCP, 8'h00, 8'h02, 0, 0);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 8'h02, 0, 1);
        push_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 8'h00, 8'h02, 0, 13);
        repeat (60) raw.push_back(8'hFF);
        push_bytes(raw);
        raw = {};
        repeat (60) raw.push_back(8'h00);
        push_bytes(raw);

        while (queued_bytes.size() < 1950)
        begin
            roll = $urandom_range(0, 99);
            tags = (roll < 70) ? 0 : (roll < 95) ? 1 : 2;
            roll = $urandom_range(0, 99);
            if (roll < 45)
                etype = ETYPE_IPV4;
            else if (roll < 80)
                etype = ETYPE_IPV6;
            else
                etype = 16'($urandom);
            case ($urandom_range(0, 4))
                0: proto = PROTO_TCP;
                1: proto = PROTO_UDP;
                2: proto = PROTO_ICMP;
                3: proto = PROTO_ICMPV6;
                default: proto = 8'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: l4_type = ICMP_ECHO_REQUEST;
                1: l4_type = ICMP_ECHO_REPLY;
                2: l4_type = ICMP6_PING_REQUEST;
                3: l4_type = ICMP6_PING_ANSWER;
                default: l4_type = 8'($urandom);
            endcase
            payload = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
            cut = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 90) : 0;
            push_frame(tags, etype, ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5,
                       proto, l4_type, 8'($urandom), payload, cut);
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        while (queued_bytes.size() != 0 || predicted_headers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/phfe_pkg.sv
design/phfe_if.sv
design/phfe_in_stage.sv
design/phfe_parse.sv
design/packet_header_field_extractor.sv
test/packet_header_field_extractor_tb.sv
